/* src/spf_pkg.sv */
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants for the sequence pattern finder: the command
// codes, the input and result item structs and the per-cell control group.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int PATTERN_DEPTH_DEF   = 16;
    localparam int TEXT_INDEX_BITS_DEF = 16;
    localparam int WORD_W              = 32;
    localparam int POS_W               = 16;
    localparam int CMD_W               = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [WORD_W-1:0] value;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             verdict;
        logic             overflow;
    } t_out_item;

    // Control broadcast to every cell for the transaction being accepted.
    typedef struct packed {
        logic load;   // append with room in the store
        logic text;   // text word, advance the partial-match chain
        logic flush;  // clear the partial-match bit
    } t_cell_ctl;

endpackage

/* src/spf_cell.sv */
// ----------------------------------------------------------------------------
// spf_cell
// One pattern position: holds one pattern word and the partial-match bit
// saying that the latest INDEX+1 text words equal pattern words 0..INDEX.
// ----------------------------------------------------------------------------
module spf_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spf_pkg::t_cell_ctl                i_ctl,
    input  logic [CNT_W-1:0]                  i_count,
    input  logic [spf_pkg::WORD_W-1:0]        i_word,
    input  logic                              i_prev_hit,
    output logic                              o_hit,
    output logic                              o_tail_hit
);

    logic [spf_pkg::WORD_W-1:0] r_word;
    logic                       r_hit;
    logic                       n_hit;
    logic                       w_active;
    logic                       w_tail;

    assign w_active = (CNT_W'(INDEX) < i_count);
    assign w_tail   = (CNT_W'(INDEX + 1) == i_count);

    // The pattern word is only read once this cell is below the fill count.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_count == CNT_W'(INDEX))) begin
            r_word <= i_word;
        end
    end

    assign n_hit = i_prev_hit & w_active & (r_word == i_word);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.flush) begin
            r_hit <= 1'b0;
        end else if (i_ctl.text) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit      = r_hit;
    assign o_tail_hit = n_hit & w_tail;

endmodule

/* src/sequence_pattern_finder_core.sv */
// ----------------------------------------------------------------------------
// sequence_pattern_finder_core
// Finds the first contiguous occurrence of a stored word pattern in a text
// stream. One transaction is taken per clock cycle unless stalled, and its
// result is shown in the output register in the next cycle; the rate is set by
// the row of pattern cells, which compare the text word against every
// alignment and hand their partial-match bits to the next cell. Append transactions
// add pattern words (dropped with overflow once PATTERN_DEPTH words are
// stored), clear empties the pattern, and text transactions report found, the
// one-based position of the word that completes the first match, and a verdict
// on that word or on the word marked last. Every transaction produces exactly
// one result. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module sequence_pattern_finder_core #(
    parameter int PATTERN_DEPTH   = spf_pkg::PATTERN_DEPTH_DEF,
    parameter int TEXT_INDEX_BITS = spf_pkg::TEXT_INDEX_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  spf_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output spf_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    localparam int CNT_W = $clog2(PATTERN_DEPTH + 1);

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic [TEXT_INDEX_BITS-1:0] r_text_idx;
    logic [TEXT_INDEX_BITS-1:0] n_text_idx;
    logic [TEXT_INDEX_BITS-1:0] w_idx_inc;
    logic                       r_found;
    logic                       n_found;
    logic [spf_pkg::POS_W-1:0]  r_found_pos;
    logic [spf_pkg::POS_W-1:0]  n_found_pos;
    logic [spf_pkg::POS_W-1:0]  w_idx_pos;
    logic                       r_out_valid;
    spf_pkg::t_out_item         r_out;
    spf_pkg::t_out_item         n_out;
    spf_pkg::t_cell_ctl         w_ctl;
    logic                       w_accept;
    logic                       w_full;
    logic                       w_match;
    logic [PATTERN_DEPTH-1:0]   w_hit;
    logic [PATTERN_DEPTH-1:0]   w_prev_hit;
    logic [PATTERN_DEPTH-1:0]   w_tail_hit;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_full     = (r_count == CNT_W'(PATTERN_DEPTH));

    assign w_ctl.load  = w_accept && (i_in_data.command == spf_pkg::CMD_APPEND) && !w_full;
    assign w_ctl.text  = w_accept && (i_in_data.command == spf_pkg::CMD_TEXT);
    assign w_ctl.flush = w_accept && ((i_in_data.command == spf_pkg::CMD_APPEND) ||
                                      (i_in_data.command == spf_pkg::CMD_CLEAR) ||
                                      ((i_in_data.command == spf_pkg::CMD_TEXT) &&
                                       i_in_data.last));

    for (genvar k = 0; k < PATTERN_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_prev_hit[k] = 1'b1;
        end else begin : g_link
            assign w_prev_hit[k] = w_hit[k-1];
        end

        spf_cell #(
            .INDEX (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_word     (i_in_data.value),
            .i_prev_hit (w_prev_hit[k]),
            .o_hit      (w_hit[k]),
            .o_tail_hit (w_tail_hit[k])
        );
    end

    // The text index saturates at its all-ones value.
    assign w_idx_inc = (r_text_idx == '1) ? r_text_idx : r_text_idx + 1'b1;

    if (TEXT_INDEX_BITS >= spf_pkg::POS_W) begin : g_pos_trunc
        assign w_idx_pos = w_idx_inc[spf_pkg::POS_W-1:0];
    end else begin : g_pos_ext
        assign w_idx_pos = {{(spf_pkg::POS_W - TEXT_INDEX_BITS){1'b0}}, w_idx_inc};
    end

    // Only the cell at the current pattern end can report a tail hit.
    assign w_match = (|w_tail_hit) & ~r_found;

    always_comb begin
        n_count     = r_count;
        n_text_idx  = r_text_idx;
        n_found     = r_found;
        n_found_pos = r_found_pos;
        n_out       = '0;
        unique case (i_in_data.command)
            spf_pkg::CMD_APPEND: begin
                if (w_full) begin
                    n_out.overflow = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
                n_text_idx  = '0;
                n_found     = 1'b0;
                n_found_pos = '0;
            end
            spf_pkg::CMD_CLEAR: begin
                n_count     = '0;
                n_text_idx  = '0;
                n_found     = 1'b0;
                n_found_pos = '0;
            end
            spf_pkg::CMD_TEXT: begin
                n_found        = r_found | w_match;
                n_found_pos    = w_match ? w_idx_pos : r_found_pos;
                n_out.found    = n_found;
                n_out.position = n_found_pos;
                n_out.verdict  = w_match | i_in_data.last;
                if (i_in_data.last) begin
                    n_text_idx  = '0;
                    n_found     = 1'b0;
                    n_found_pos = '0;
                end else begin
                    n_text_idx = w_idx_inc;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_text_idx  <= '0;
            r_found     <= 1'b0;
            r_found_pos <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_text_idx  <= n_text_idx;
                r_found     <= n_found;
                r_found_pos <= n_found_pos;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PATTERN_DEPTH))
        else $error("pattern count beyond store depth");

    a_overflow_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in_data.command == spf_pkg::CMD_APPEND) && !w_full
        |=> !o_out_data.overflow)
        else $error("overflow reported with room in the store");

    a_last_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.text && i_in_data.last |=> (r_text_idx == '0) && !r_found && !(|w_hit))
        else $error("search state not cleared after last text word");

    a_non_text_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in_data.command != spf_pkg::CMD_TEXT)
        |=> o_out_valid && !o_out_data.found && !o_out_data.verdict)
        else $error("non-text transaction reported a match");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sequence_pattern_finder_core. A scoreboard class
// predicts one result per accepted command from its own copy of the pattern
// store and search state and checks each result in order. Stimulus covers
// directed corner cases and random searches with random idle bursts on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [spf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int               CYCLE_LIMIT  = 1000000;
    localparam int               RANDOM_ITEMS = 1650;
    localparam int               QUIET_ITEMS  = 250;

    class pattern_search_scoreboard;
        logic [spf_pkg::WORD_W-1:0]              words[spf_pkg::PATTERN_DEPTH_DEF];
        int                                      stored;
        logic [spf_pkg::PATTERN_DEPTH_DEF-1:0]   alive;
        logic [spf_pkg::TEXT_INDEX_BITS_DEF-1:0] text_pos;
        logic                                    hit;
        logic [spf_pkg::TEXT_INDEX_BITS_DEF-1:0] hit_pos;
        spf_pkg::t_out_item                      pending_results[$];
        int                                      errors;

        function new();
            stored   = 0;
            errors   = 0;
            restart();
        endfunction

        function void restart();
            alive    = '0;
            text_pos = '0;
            hit      = 1'b0;
            hit_pos  = '0;
        endfunction

        task report(input string msg);
            if (errors < 50)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Predict the result of one accepted command.
        function void take_command(input spf_pkg::t_in_item it);
            spf_pkg::t_out_item                    r;
            logic [spf_pkg::PATTERN_DEPTH_DEF-1:0] eq;
            logic                                  first_hit;
            r         = '0;
            eq        = '0;
            first_hit = 1'b0;
            case (it.command)
                spf_pkg::CMD_APPEND: begin
                    if (stored < spf_pkg::PATTERN_DEPTH_DEF) begin
                        words[stored] = it.value;
                        stored++;
                    end else begin
                        r.overflow = 1'b1;
                    end
                    restart();
                end
                spf_pkg::CMD_CLEAR: begin
                    stored = 0;
                    restart();
                end
                spf_pkg::CMD_TEXT: begin
                    if (text_pos != '1)
                        text_pos++;
                    for (int k = 0; k < stored; k++)
                        if (words[k] == it.value)
                            eq[k] = 1'b1;
                    // Every alignment advances at once; bit k means k+1 words match.
                    alive = ((alive << 1) | 1'b1) & eq;
                    if (stored > 0 && !hit && alive[stored-1]) begin
                        hit       = 1'b1;
                        hit_pos   = text_pos;
                        first_hit = 1'b1;
                    end
                    r.found    = hit;
                    r.position = hit_pos[spf_pkg::POS_W-1:0];
                    r.verdict  = first_hit | it.last;
                    if (it.last)
                        restart();
                end
                default: begin
                end
            endcase
            pending_results.push_back(r);
        endfunction

        task check_result(input spf_pkg::t_out_item got);
            spf_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %p with none expected", got));
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found)
                    report($sformatf("found %b, expected %b", got.found, want.found));
                if (got.position !== want.position)
                    report($sformatf("position %0d, expected %0d",
                                     got.position, want.position));
                if (got.verdict !== want.verdict)
                    report($sformatf("verdict %b, expected %b", got.verdict, want.verdict));
                if (got.overflow !== want.overflow)
                    report($sformatf("overflow %b, expected %b",
                                     got.overflow, want.overflow));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    spf_pkg::t_in_item  i_in_data;
    logic               o_in_stall;
    logic               o_out_valid;
    spf_pkg::t_out_item o_out_data;
    logic               i_out_stall = 1'b0;

    pattern_search_scoreboard board;
    bit        idle_on;
    int        items_sent;
    int        stall_left = 0;
    int        cycles = 0;
    logic [spf_pkg::WORD_W-1:0] extreme_words[4] = '{32'h0000_0000, 32'h8000_0000,
                                                     32'h7FFF_FFFF, 32'hFFFF_FFFF};

    sequence_pattern_finder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #2;
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Transaction monitor for both channels.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                board.take_command(i_in_data);
            if (o_out_valid && !i_out_stall)
                board.check_result(o_out_data);
        end
    end

    // Receiver back-pressure in random bursts.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 13);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic [spf_pkg::CMD_W-1:0] cmd,
                             input logic [spf_pkg::WORD_W-1:0] value,
                             input logic last);
        spf_pkg::t_in_item it;
        int                gap;
        it.command = cmd;
        it.value   = value;
        it.last    = last;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // One random search: optional clear, pattern loads, then a text ending on last.
    task automatic run_search();
        logic [spf_pkg::WORD_W-1:0] alphabet[3];
        logic [spf_pkg::WORD_W-1:0] pat[$];
        logic [spf_pkg::WORD_W-1:0] txt[$];
        logic [spf_pkg::WORD_W-1:0] w;
        int                         plen, tlen, at, pick, letters;
        for (int i = 0; i < 3; i++)
            alphabet[i] = $urandom;
        if ($urandom_range(0, 3) == 0)
            alphabet[0] = extreme_words[$urandom_range(0, 3)];
        letters = ($urandom_range(0, 2) == 0) ? 2 : 3;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            plen = 0;
        else if (pick <= 2)
            plen = $urandom_range(12, 19);
        else
            plen = $urandom_range(1, 5);
        tlen = $urandom_range(1, 24);
        for (int i = 0; i < plen; i++)
            pat.push_back(alphabet[$urandom_range(0, letters - 1)]);
        for (int i = 0; i < tlen; i++)
            txt.push_back(alphabet[$urandom_range(0, letters - 1)]);
        if (plen > 0 && plen <= tlen && $urandom_range(0, 1) == 1) begin
            at = $urandom_range(0, tlen - plen);
            for (int i = 0; i < plen; i++)
                txt[at + i] = pat[i];
        end

        if ($urandom_range(0, 9) != 0)
            send_item(spf_pkg::CMD_CLEAR, $urandom, $urandom_range(0, 1));
        foreach (pat[i])
            send_item(spf_pkg::CMD_APPEND, pat[i], $urandom_range(0, 1));
        foreach (txt[i]) begin
            if ($urandom_range(0, 29) == 0) begin
                // A stray command in the middle of the text.
                if ($urandom_range(0, 1) == 0)
                    send_item(CMD_UNUSED, $urandom, $urandom_range(0, 1));
                else
                    send_item(spf_pkg::CMD_APPEND, alphabet[0], 1'b0);
            end
            w = ($urandom_range(0, 24) == 0) ? $urandom : txt[i];
            send_item(spf_pkg::CMD_TEXT, w, (i == tlen - 1) || ($urandom_range(0, 39) == 0));
        end
    endtask

    initial begin
        logic [spf_pkg::WORD_W-1:0] lo, hi;
        int                         base;
        board       = new();
        items_sent  = 0;
        idle_on     = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
        // Empty pattern is never found; the unused command code is ignored.
        send_item(spf_pkg::CMD_TEXT, 32'h0, 1'b1);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1);
        // First match at word 3, later overlapping match ignored, verdict on last.
        send_item(spf_pkg::CMD_APPEND, lo, 1'b0);
        send_item(spf_pkg::CMD_APPEND, hi, 1'b0);
        send_item(spf_pkg::CMD_APPEND, lo, 1'b0);
        send_item(spf_pkg::CMD_TEXT, lo, 1'b0);
        send_item(spf_pkg::CMD_TEXT, hi, 1'b0);
        send_item(spf_pkg::CMD_TEXT, lo, 1'b0);
        send_item(spf_pkg::CMD_TEXT, hi, 1'b0);
        send_item(spf_pkg::CMD_TEXT, lo, 1'b1);
        // Overlapping restart: pattern lo lo hi inside lo lo lo hi.
        send_item(spf_pkg::CMD_CLEAR, 32'h0, 1'b0);
        send_item(spf_pkg::CMD_APPEND, lo, 1'b0);
        send_item(spf_pkg::CMD_APPEND, lo, 1'b0);
        send_item(spf_pkg::CMD_APPEND, hi, 1'b0);
        send_item(spf_pkg::CMD_TEXT, lo, 1'b0);
        send_item(spf_pkg::CMD_TEXT, lo, 1'b0);
        send_item(spf_pkg::CMD_TEXT, lo, 1'b0);
        send_item(spf_pkg::CMD_TEXT, hi, 1'b1);
        // Text shorter than the pattern.
        send_item(spf_pkg::CMD_TEXT, lo, 1'b0);
        send_item(spf_pkg::CMD_TEXT, lo, 1'b1);

        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS) begin
            if (items_sent >= base + RANDOM_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            run_search();
        end
        idle_on = 1'b0;
        i_in_valid <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
src/spf_pkg.sv
src/spf_cell.sv
src/sequence_pattern_finder_core.sv
verif/tb_top.sv
